/* src/gbci_pkg.sv */
// Shared types and constants for the gyro bias calibration and rate integration block.
// Used by the top level, the shared divider and the port checker; depends on nothing.
package gbci_pkg;

	localparam int MAX_CAL_SAMPLES = 64;
	localparam int SAMPLE_BITS     = 10;
	localparam int CNT_W           = 7;
	localparam int ACC_W           = 16;
	localparam int DIV_STEPS       = ACC_W;

	// register indexes of the configuration port
	localparam logic CFG_CAL_SAMPLES = 1'b0;
	localparam logic CFG_YAW_HALF    = 1'b1;

	// item function codes
	localparam logic FUNC_SAMPLE  = 1'b0;
	localparam logic FUNC_RESTART = 1'b1;

	typedef struct packed {
		logic                   func;
		logic [SAMPLE_BITS-1:0] roll_sample;
		logic [SAMPLE_BITS-1:0] pitch_sample;
		logic [SAMPLE_BITS-1:0] yaw_sample;
		logic signed [15:0]     roll_drift_fix;
		logic signed [15:0]     pitch_drift_fix;
		logic signed [7:0]      yaw_stick;
	} in_item_t;

	typedef struct packed {
		logic signed [15:0] roll_att;
		logic signed [15:0] pitch_att;
		logic signed [15:0] yaw_att;
		logic signed [7:0]  roll_rate_byte;
		logic signed [7:0]  pitch_rate_byte;
		logic signed [7:0]  yaw_rate_byte;
		logic               calibrating;
	} out_item_t;

	// divider command and status
	typedef struct packed {
		logic             start;
		logic [ACC_W-1:0] dividend;
		logic [CNT_W-1:0] divisor;
	} div_ctl_t;

	typedef struct packed {
		logic             busy;
		logic             done;
		logic [ACC_W-1:0] quotient;
	} div_sts_t;

	// saturate the calibration count register to the supported maximum
	function automatic logic [CNT_W-1:0] eff_count(input logic [CNT_W-1:0] c);
		if (c > CNT_W'(MAX_CAL_SAMPLES)) begin
			return CNT_W'(MAX_CAL_SAMPLES);
		end
		return c;
	endfunction

endpackage

/* src/gbci_div.sv */
// Shared restoring divider: 16-bit dividend by a small unsigned divisor, one bit per cycle.
// Depends on gbci_pkg for widths and the command/status structs.
module gbci_div (
	input  logic              clk,
	input  logic              arst_n,
	input  gbci_pkg::div_ctl_t ctl,
	output gbci_pkg::div_sts_t sts
);
	import gbci_pkg::*;

	localparam int STEP_W = $clog2(DIV_STEPS + 1);

	logic [ACC_W-1:0]  dvd_q;
	logic [CNT_W-1:0]  rem_q;
	logic [CNT_W-1:0]  dsr_q;
	logic [STEP_W-1:0] step_q;
	logic              busy_q;
	logic              done_q;

	logic [CNT_W:0] trial;
	logic [CNT_W:0] diff;
	logic           ge;
	logic           last_step;

	// trial subtract of the next partial remainder
	always_comb begin
		trial = {rem_q, dvd_q[ACC_W-1]};
		diff  = trial - {1'b0, dsr_q};
		ge    = trial >= {1'b0, dsr_q};
	end

	assign last_step = busy_q && !ctl.start && (step_q == STEP_W'(DIV_STEPS - 1));

	// sequence control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= last_step;
			if (ctl.start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + STEP_W'(1);
				if (last_step) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	// shift quotient bits into the dividend register
	always_ff @(posedge clk) begin
		if (ctl.start) begin
			dvd_q <= ctl.dividend;
			rem_q <= '0;
			dsr_q <= ctl.divisor;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[ACC_W-2:0], ge};
			rem_q <= ge ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
		end
	end

	assign sts.busy     = busy_q;
	assign sts.done     = done_q;
	assign sts.quotient = dvd_q;

endmodule

/* src/gyro_bias_calibrate_integrate.sv */
// Gyro bias calibration and rate integration, top level.
// Depends on gbci_pkg and the shared divider gbci_div.
//
// One item is taken at a time; in_stall stays high from acceptance until its result has
// moved into the output register. A restart, an ordinary calibration sample or a run sample
// goes straight to the push state. After the last calibration sample the three bias sums are
// divided one after another by the sample count in one shared 16-step restoring divider.
// The output register holds a result while out_stall is high, and the block accepts the next
// item meanwhile. No memories, no clearing pass after reset.
module gyro_bias_calibrate_integrate (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  gbci_pkg::in_item_t  in_item,
	output logic                out_valid,
	input  logic                out_stall,
	output gbci_pkg::out_item_t out_item,
	input  logic                cfg_we,
	input  logic                cfg_index,
	input  logic [gbci_pkg::CNT_W-1:0] cfg_wdata
);
	import gbci_pkg::*;

	localparam logic [1:0] ST_IDLE   = 2'd0;
	localparam logic [1:0] ST_DSTART = 2'd1;
	localparam logic [1:0] ST_DWAIT  = 2'd2;
	localparam logic [1:0] ST_PUSH   = 2'd3;

	localparam logic [1:0] AX_ROLL  = 2'd0;
	localparam logic [1:0] AX_PITCH = 2'd1;
	localparam logic [1:0] AX_YAW   = 2'd2;

	logic [1:0]       state_q;
	logic [1:0]       axis_q;
	logic [CNT_W-1:0] cal_cfg_q;
	logic             yaw_half_q;
	logic [CNT_W-1:0] samples_left_q;
	logic [CNT_W-1:0] n_q;
	logic [ACC_W-1:0] bias_q  [3];
	logic [ACC_W-1:0] angle_q [3];
	out_item_t        res_d;
	out_item_t        res_q;
	out_item_t        out_item_q;
	logic             out_valid_q;

	div_ctl_t div_ctl;
	div_sts_t div_sts;

	logic             accept;
	logic             push;
	logic [CNT_W-1:0] eff;
	logic [ACC_W-1:0] sum_r, sum_p, sum_y;
	logic [16:0]      rr, pr, yr, yr_adj, yr_h;
	logic [17:0]      yw;
	logic [ACC_W-1:0] ang_r, ang_p, ang_y;

	// rate / 4 truncated toward zero, low 8 bits
	function automatic logic [7:0] quarter17(input logic [16:0] x);
		logic [16:0] adj;
		adj = x + {15'b0, x[16], x[16]};
		return adj[9:2];
	endfunction

	function automatic logic [7:0] quarter18(input logic [17:0] x);
		logic [17:0] adj;
		adj = x + {16'b0, x[17], x[17]};
		return adj[9:2];
	endfunction

	assign in_stall = state_q != ST_IDLE;
	assign accept   = in_valid && !in_stall;
	assign push     = (state_q == ST_PUSH) && (!out_valid_q || !out_stall);
	assign eff      = eff_count(cal_cfg_q);

	// bias sums and run-time rates, angles
	always_comb begin
		sum_r  = bias_q[AX_ROLL] + ACC_W'(in_item.roll_sample);
		sum_p  = bias_q[AX_PITCH] + ACC_W'(in_item.pitch_sample);
		sum_y  = bias_q[AX_YAW] + ACC_W'(in_item.yaw_sample);
		rr     = 17'(in_item.roll_sample) - {1'b0, bias_q[AX_ROLL]};
		pr     = 17'(in_item.pitch_sample) - {1'b0, bias_q[AX_PITCH]};
		yr     = 17'(in_item.yaw_sample) - {1'b0, bias_q[AX_YAW]};
		yr_adj = yr + {16'b0, yr[16]};
		yr_h   = yaw_half_q ? {yr_adj[16], yr_adj[16:1]} : yr;
		yw     = {yr_h[16], yr_h} + {{10{in_item.yaw_stick[7]}}, in_item.yaw_stick};
		ang_r  = angle_q[AX_ROLL] + rr[ACC_W-1:0] + in_item.roll_drift_fix;
		ang_p  = angle_q[AX_PITCH] + pr[ACC_W-1:0] + in_item.pitch_drift_fix;
		ang_y  = angle_q[AX_YAW] + yw[ACC_W-1:0];
	end

	// drive the shared divider
	always_comb begin
		div_ctl.start    = state_q == ST_DSTART;
		div_ctl.dividend = bias_q[axis_q] + ACC_W'(n_q >> 1);
		div_ctl.divisor  = n_q;
	end

	gbci_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (div_ctl),
		.sts    (div_sts)
	);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cal_cfg_q  <= CNT_W'(MAX_CAL_SAMPLES);
			yaw_half_q <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_CAL_SAMPLES: cal_cfg_q <= cfg_wdata;
				CFG_YAW_HALF:    yaw_half_q <= cfg_wdata[0];
				default:         ;
			endcase
		end
	end

	// sequencer and block state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			axis_q         <= AX_ROLL;
			samples_left_q <= CNT_W'(MAX_CAL_SAMPLES);
			n_q            <= CNT_W'(1);
			for (int i = 0; i < 3; i++) begin
				bias_q[i]  <= '0;
				angle_q[i] <= '0;
			end
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (in_item.func == FUNC_RESTART) begin
							samples_left_q <= eff;
							for (int i = 0; i < 3; i++) begin
								bias_q[i]  <= '0;
								angle_q[i] <= '0;
							end
							state_q <= ST_PUSH;
						end else if (samples_left_q != '0) begin
							bias_q[AX_ROLL]  <= sum_r;
							bias_q[AX_PITCH] <= sum_p;
							bias_q[AX_YAW]   <= sum_y;
							for (int i = 0; i < 3; i++) begin
								angle_q[i] <= '0;
							end
							samples_left_q <= samples_left_q - CNT_W'(1);
							if (samples_left_q == CNT_W'(1)) begin
								n_q     <= (eff == '0) ? CNT_W'(1) : eff;
								axis_q  <= AX_ROLL;
								state_q <= ST_DSTART;
							end else begin
								state_q <= ST_PUSH;
							end
						end else begin
							angle_q[AX_ROLL]  <= ang_r;
							angle_q[AX_PITCH] <= ang_p;
							angle_q[AX_YAW]   <= ang_y;
							state_q           <= ST_PUSH;
						end
					end
				end
				ST_DSTART: begin
					state_q <= ST_DWAIT;
				end
				ST_DWAIT: begin
					if (div_sts.done) begin
						bias_q[axis_q] <= div_sts.quotient;
						if (axis_q == AX_YAW) begin
							state_q <= ST_PUSH;
						end else begin
							axis_q  <= axis_q + 2'd1;
							state_q <= ST_DSTART;
						end
					end
				end
				ST_PUSH: begin
					if (push) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// form the result of the item being accepted
	always_comb begin
		res_d = '0;
		if (in_item.func == FUNC_RESTART) begin
			res_d.calibrating = eff != '0;
		end else if (samples_left_q != '0) begin
			res_d.calibrating = 1'b1;
		end else begin
			res_d.roll_att        = ang_r;
			res_d.pitch_att       = ang_p;
			res_d.yaw_att         = ang_y;
			res_d.roll_rate_byte  = quarter17(rr);
			res_d.pitch_rate_byte = quarter17(pr);
			res_d.yaw_rate_byte   = quarter18(yw);
		end
	end

	// hold the result of the accepted item
	always_ff @(posedge clk) begin
		if (accept) begin
			res_q <= res_d;
		end
	end

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (push) begin
			out_valid_q <= 1'b1;
		end else if (out_valid_q && !out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (push) begin
			out_item_q <= res_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_item_q;

endmodule

/* src/gbci_checker.sv */
// Port-level checker for gyro_bias_calibrate_integrate, attached by the bind below.
// Depends on gbci_pkg for the item types.
module gbci_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                in_valid,
	input logic                in_stall,
	input logic                out_valid,
	input logic                out_stall,
	input gbci_pkg::out_item_t out_item
);
	import gbci_pkg::*;

	// an accepted item keeps the block busy on the next cycle
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input not stalled after an item was accepted");

	// a new result only follows a busy cycle
	a_result_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_stall))
		else $error("result appeared without a preceding busy cycle");

	// calibration results carry zero angles and rates
	a_cal_result_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_item.calibrating |->
			out_item.roll_att == '0 && out_item.pitch_att == '0 &&
			out_item.yaw_att == '0 && out_item.roll_rate_byte == '0 &&
			out_item.pitch_rate_byte == '0 && out_item.yaw_rate_byte == '0)
		else $error("calibration result with nonzero angle or rate");

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_item))
		else $error("stalled result changed or dropped");

endmodule

bind gyro_bias_calibrate_integrate gbci_checker u_gbci_checker (.*);
